FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property, disabled while reset is high
`define BMW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication form, disabled while reset is high
`define BMW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BMW_ASSERT(lbl, clk, rst, prop, msg)
`define BMW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bmw_pkg.sv
// ----------------------------------------------------------------------------
// bmw_pkg
// Types, codes and constants of the ext2 block map walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmw_pkg;

   // default configuration of the map
   localparam int POINTER_SLOTS_DEF      = 15;
   localparam int DIRECT_SLOTS_DEF       = 12;
   localparam int MAX_LOG_BLOCK_SIZE_DEF = 6;

   // log2 of the 1 KiB base block and of its 256 entries
   localparam int BLOCK_LOG_BASE = 10;
   localparam int ENTRY_LOG_BASE = 8;
   localparam int MAX_LEVELS     = 3;

   localparam int WORD_W = 32;
   localparam int ADDR_W = 48;

   // request actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_XLATE = 2'd1;
   localparam logic [1:0] ACT_RESP  = 2'd2;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic [1:0]        action;
      logic [3:0]        slot;
      logic [WORD_W-1:0] pointer_value;
      logic [WORD_W-1:0] logical_block;
      logic [WORD_W-1:0] read_word;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] read_byte_address;
      logic [WORD_W-1:0] physical_block;
      logic              found;
   } rsp_type;

   // decoded item handed from the front stage to the walk stage
   typedef struct packed {
      logic [1:0]        action;
      logic              direct;
      logic              beyond;
      logic [1:0]        level;
      logic [WORD_W-1:0] rel_block;
      logic [WORD_W-1:0] read_word;
   } stage_type;

endpackage

FILE: rtl/core/bmw_ptr_table.sv
// ----------------------------------------------------------------------------
// bmw_ptr_table
// Pointer table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmw_ptr_table #(
   parameter int POINTER_SLOTS = bmw_pkg::POINTER_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(POINTER_SLOTS)-1:0]     wr_addr,
   input  logic [bmw_pkg::WORD_W-1:0]           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(POINTER_SLOTS)-1:0]     rd_addr,
   output logic [bmw_pkg::WORD_W-1:0]           rd_data
);

   logic [bmw_pkg::WORD_W-1:0] mem [POINTER_SLOTS];
   logic [bmw_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered and held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bmw_front.sv
// ----------------------------------------------------------------------------
// bmw_front
// Front stage: sorts a logical block into direct or indirect level, forms the
// block offset inside that level and issues the pointer table read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmw_front #(
   parameter int POINTER_SLOTS      = bmw_pkg::POINTER_SLOTS_DEF,
   parameter int DIRECT_SLOTS       = bmw_pkg::DIRECT_SLOTS_DEF,
   parameter int MAX_LOG_BLOCK_SIZE = bmw_pkg::MAX_LOG_BLOCK_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [2:0]                        eff_log,
   input  logic                              req_accept,
   input  bmw_pkg::req_type                  req_data,
   input  logic                              stage_go,
   output logic                              stage_valid,
   output bmw_pkg::stage_type                stage_data,
   output logic                              tbl_rd_en,
   output logic [$clog2(POINTER_SLOTS)-1:0]  tbl_rd_addr
);

   localparam int SLOT_W   = $clog2(POINTER_SLOTS);
   localparam int NLEV_RAW = POINTER_SLOTS - DIRECT_SLOTS;
   localparam int NLEV     = (NLEV_RAW < 0) ? 0 :
                             (NLEV_RAW > bmw_pkg::MAX_LEVELS) ? bmw_pkg::MAX_LEVELS :
                             NLEV_RAW;
   localparam int CAP_W    = bmw_pkg::MAX_LEVELS *
                             (bmw_pkg::ENTRY_LOG_BASE + MAX_LOG_BLOCK_SIZE);
   localparam int TH_W     = ((CAP_W > bmw_pkg::WORD_W) ? CAP_W : bmw_pkg::WORD_W) + 2;

   logic [3:0]               sh;
   logic [4:0]               sh2;
   logic [5:0]               sh3;
   logic [TH_W-1:0]          cap0, cap1, cap2;
   logic [TH_W-1:0]          th0, th1, th2;
   logic [TH_W-1:0]          lb_w;
   logic [TH_W-1:0]          base;
   logic [1:0]               level;
   logic                     direct;
   logic                     beyond;
   logic                     enter;
   bmw_pkg::stage_type       dec;

   logic                     valid_ff, valid_in;
   bmw_pkg::stage_type       data_ff;

   // level thresholds from the current block size
   always_comb begin
      sh   = 4'(bmw_pkg::ENTRY_LOG_BASE) + {1'b0, eff_log};
      sh2  = {1'b0, sh} + {1'b0, sh};
      sh3  = {1'b0, sh2} + {2'b00, sh};
      cap0 = TH_W'(1) << sh;
      cap1 = TH_W'(1) << sh2;
      cap2 = TH_W'(1) << sh3;
      th0  = TH_W'(DIRECT_SLOTS) + cap0;
      th1  = th0 + cap1;
      th2  = th1 + cap2;
   end

   // pick the level and the offset inside it
   always_comb begin
      lb_w   = TH_W'(req_data.logical_block);
      direct = (lb_w < TH_W'(DIRECT_SLOTS));
      priority if (lb_w < th0) begin
         level = 2'd0;
         base  = TH_W'(DIRECT_SLOTS);
      end else if (lb_w < th1) begin
         level = 2'd1;
         base  = th0;
      end else if (lb_w < th2) begin
         level = 2'd2;
         base  = th1;
      end else begin
         level = 2'd3;
         base  = th2;
      end
      beyond = !direct && ({1'b0, level} >= 3'(NLEV));

      dec.action    = req_data.action;
      dec.direct    = direct;
      dec.beyond    = beyond;
      dec.level     = level;
      dec.rel_block = bmw_pkg::WORD_W'(lb_w - base);
      dec.read_word = req_data.read_word;
   end

   // table read for a translate: direct slot or root of the level
   assign tbl_rd_en   = req_accept && (req_data.action == bmw_pkg::ACT_XLATE) && !beyond;
   assign tbl_rd_addr = direct ? req_data.logical_block[SLOT_W-1:0]
                               : SLOT_W'(DIRECT_SLOTS) + SLOT_W'(level);

   // only translates and read responses go on to the walk stage
   assign enter = req_accept && ((req_data.action == bmw_pkg::ACT_XLATE) ||
                                 (req_data.action == bmw_pkg::ACT_RESP));

   always_comb begin
      if (enter) begin
         valid_in = 1'b1;
      end else if (stage_go) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         data_ff <= dec;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

FILE: rtl/core/bmw_walk.sv
// ----------------------------------------------------------------------------
// bmw_walk
// Walk stage: holds the walk state, turns translates and read responses into
// read requests or finished answers, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmw_walk #(
   parameter int MAX_LOG_BLOCK_SIZE = bmw_pkg::MAX_LOG_BLOCK_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    eff_log,
   input  logic                          stage_valid,
   input  bmw_pkg::stage_type            stage_data,
   input  logic [bmw_pkg::WORD_W-1:0]    tbl_data,
   output logic                          stage_go,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bmw_pkg::rsp_type              rsp_data
);

   localparam int IDX_W = bmw_pkg::ENTRY_LOG_BASE + MAX_LOG_BLOCK_SIZE;

   // walk state
   logic                 busy_ff, busy_in;
   logic [1:0]           levels_left_ff, levels_left_in;
   logic [1:0]           walk_pos_ff, walk_pos_in;
   logic [IDX_W-1:0]     idx_ff [3];
   logic [IDX_W-1:0]     idx_in [3];

   // result register
   logic                 out_valid_ff, out_valid_in;
   bmw_pkg::rsp_type     out_data_ff;

   logic                 fire;
   logic [3:0]           sh;
   logic [4:0]           blk_shift;
   logic [IDX_W-1:0]     idx_mask;
   logic [4:0]           amt [3];
   logic [IDX_W-1:0]     new_idx [3];
   logic [1:0]           left_dec;
   logic [1:0]           pos_next;
   logic                 res_valid;
   logic                 res_done;
   logic [bmw_pkg::WORD_W-1:0] res_blk;
   logic [IDX_W-1:0]     res_idx;
   bmw_pkg::rsp_type     res;
   logic [2:0]           pos_sum;

   assign stage_go = !out_valid_ff || rsp_ready;
   assign fire     = stage_valid && stage_go;

   // split the level offset into one entry index per level
   always_comb begin
      sh        = 4'(bmw_pkg::ENTRY_LOG_BASE) + {1'b0, eff_log};
      blk_shift = 5'(bmw_pkg::BLOCK_LOG_BASE) + {2'b00, eff_log};
      for (int i = 0; i < IDX_W; i++) begin
         idx_mask[i] = (5'(i) < {1'b0, sh});
      end
      for (int j = 0; j < 3; j++) begin
         unique case (2'(stage_data.level - 2'(j)))
            2'd0:    amt[j] = 5'd0;
            2'd1:    amt[j] = {1'b0, sh};
            default: amt[j] = {1'b0, sh} + {1'b0, sh};
         endcase
         new_idx[j] = IDX_W'(stage_data.rel_block >> amt[j]) & idx_mask;
      end
   end

   // next walk state and result
   always_comb begin
      busy_in        = busy_ff;
      levels_left_in = levels_left_ff;
      walk_pos_in    = walk_pos_ff;
      for (int j = 0; j < 3; j++) begin
         idx_in[j] = idx_ff[j];
      end
      res_valid = 1'b0;
      res_done  = 1'b0;
      res_blk   = '0;
      res_idx   = '0;
      left_dec  = levels_left_ff - 2'd1;
      pos_next  = walk_pos_ff + 2'd1;

      if (fire) begin
         unique case (stage_data.action)
            bmw_pkg::ACT_XLATE: begin
               busy_in        = 1'b0;
               levels_left_in = 2'd0;
               walk_pos_in    = 2'd0;
               for (int j = 0; j < 3; j++) begin
                  idx_in[j] = new_idx[j];
               end
               res_valid = 1'b1;
               res_done  = 1'b1;
               if (stage_data.direct) begin
                  res_blk = tbl_data;
               end else if (stage_data.beyond || (tbl_data == '0)) begin
                  res_blk = '0;
               end else begin
                  busy_in        = 1'b1;
                  levels_left_in = stage_data.level + 2'd1;
                  res_done       = 1'b0;
                  res_blk        = tbl_data;
                  res_idx        = new_idx[0];
               end
            end
            bmw_pkg::ACT_RESP: begin
               if (busy_ff && (levels_left_ff != 2'd0)) begin
                  res_valid = 1'b1;
                  res_blk   = stage_data.read_word;
                  if ((stage_data.read_word == '0) || (left_dec == 2'd0)) begin
                     busy_in        = 1'b0;
                     levels_left_in = 2'd0;
                     walk_pos_in    = 2'd0;
                     res_done       = 1'b1;
                  end else begin
                     levels_left_in = left_dec;
                     walk_pos_in    = pos_next;
                     res_idx        = idx_ff[pos_next];
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // format the result item
      res.kind              = res_done ? bmw_pkg::KIND_DONE : bmw_pkg::KIND_READ;
      res.read_byte_address = res_done ? '0 :
                              (bmw_pkg::ADDR_W'(res_blk) << blk_shift) +
                              bmw_pkg::ADDR_W'({res_idx, 2'b00});
      res.physical_block    = res_done ? res_blk : '0;
      res.found             = res_done && (res_blk != '0);
   end

   // result register fills on a producing item, empties on transfer
   assign out_valid_in = stage_go ? (fire && res_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         levels_left_ff <= 2'd0;
         walk_pos_ff    <= 2'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         levels_left_ff <= levels_left_in;
         walk_pos_ff    <= walk_pos_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         idx_ff[j] <= idx_in[j];
      end
      if (fire && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   assign pos_sum = {1'b0, walk_pos_ff} + {1'b0, levels_left_ff};

   `BMW_ASSERT_IMPL(a_busy_has_reads, clock, reset, busy_ff, levels_left_ff != 2'd0, "busy walk with no outstanding read")
   `BMW_ASSERT_IMPL(a_idle_clean, clock, reset, !busy_ff, (walk_pos_ff == 2'd0) && (levels_left_ff == 2'd0), "idle walk state not cleared")
   `BMW_ASSERT(a_depth_bound, clock, reset, pos_sum <= 3'd3, "walk position plus reads left exceeds three levels")
   `BMW_ASSERT_IMPL(a_read_needs_walk, clock, reset, out_valid_ff && (out_data_ff.kind == bmw_pkg::KIND_READ), busy_ff, "read request pending without a walk")
   `BMW_ASSERT_IMPL(a_done_format, clock, reset, out_valid_ff && (out_data_ff.kind == bmw_pkg::KIND_DONE), (out_data_ff.read_byte_address == '0) && (out_data_ff.found == (out_data_ff.physical_block != '0)), "finished result malformed")

endmodule

FILE: rtl/core/ext2_block_map_walker.sv
// ----------------------------------------------------------------------------
// ext2_block_map_walker
// Logical to device block translation through the ext2 direct and indirect
// block map, one pointer level per item.
// ----------------------------------------------------------------------------
//  channel  | direction | payload               | transfer
//  req_     | in        | bmw_pkg::req_type     | req_valid & req_ready
//  rsp_     | out       | bmw_pkg::rsp_type     | rsp_valid & rsp_ready
//  csr_     | in        | log_block_size [2:0]  | csr_valid & csr_ready
//
// One item per cycle while the result register is not stalled. Level decode
// and table read at transfer feed the walk step, whose result is registered.
// Loads write the pointer table at transfer and give no result.
// Reset holds req_ready and csr_ready low and clears the walk state, the result
// register and log_block_size; the pointer table holds garbage until loaded.
// A stalled result register stalls the walk stage and then req_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ext2_block_map_walker #(
   parameter int POINTER_SLOTS      = bmw_pkg::POINTER_SLOTS_DEF,
   parameter int DIRECT_SLOTS       = bmw_pkg::DIRECT_SLOTS_DEF,
   parameter int MAX_LOG_BLOCK_SIZE = bmw_pkg::MAX_LOG_BLOCK_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmw_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);

   localparam int SLOT_W = $clog2(POINTER_SLOTS);

   logic [2:0]                 log_bs_ff;
   logic [2:0]                 eff_log;
   logic                       req_accept;
   logic                       stage_valid;
   logic                       stage_go;
   bmw_pkg::stage_type         stage_data;
   logic                       tbl_wr_en;
   logic                       tbl_rd_en;
   logic [SLOT_W-1:0]          tbl_rd_addr;
   logic [bmw_pkg::WORD_W-1:0] tbl_data;

   // block size register
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_bs_ff <= 3'd0;
      end else if (csr_valid) begin
         log_bs_ff <= csr_data;
      end
   end

   assign eff_log = (log_bs_ff > 3'(MAX_LOG_BLOCK_SIZE)) ? 3'(MAX_LOG_BLOCK_SIZE) : log_bs_ff;

   // input transfer
   assign req_ready  = !reset && (!stage_valid || stage_go);
   assign req_accept = req_valid && req_ready;
   assign tbl_wr_en  = req_accept && (req_data.action == bmw_pkg::ACT_LOAD) &&
                       ({1'b0, req_data.slot} < 5'(POINTER_SLOTS));

   bmw_ptr_table #(
      .POINTER_SLOTS (POINTER_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_data.slot[SLOT_W-1:0]),
      .wr_data (req_data.pointer_value),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_data)
   );

   bmw_front #(
      .POINTER_SLOTS      (POINTER_SLOTS),
      .DIRECT_SLOTS       (DIRECT_SLOTS),
      .MAX_LOG_BLOCK_SIZE (MAX_LOG_BLOCK_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .eff_log     (eff_log),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .stage_go    (stage_go),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr)
   );

   bmw_walk #(
      .MAX_LOG_BLOCK_SIZE (MAX_LOG_BLOCK_SIZE)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .eff_log     (eff_log),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .tbl_data    (tbl_data),
      .stage_go    (stage_go),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
